// ----- hdl/lerb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lerb_pkg
// Shared types and fixed field widths of the log entry ring buffer.
// ----------------------------------------------------------------------------
package lerb_pkg;

   // fixed field widths
   localparam int OP_W      = 3;
   localparam int DATA_W    = 32;
   localparam int PCOUNT_W  = 6;
   localparam int AMOUNT_W  = 11;
   localparam int USAGE_W   = 10;
   localparam int THRESH_W  = 11;
   localparam int COUNT_W   = 32;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 11'd768;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_ENTRY_START = 3'd0,
      OP_PARAM_WORD  = 3'd1,
      OP_PEEK        = 3'd2,
      OP_RELEASE     = 3'd3,
      OP_CLEAR_ALL   = 3'd4
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_PEEK_FAIL = 2'd2,
      ST_NO_PARAM  = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_CLEAR  = 3'd0,
      S_IDLE   = 3'd1,
      S_REDUCE = 3'd2,
      S_EXEC   = 3'd3,
      S_PEEK   = 3'd4
   } state_type;

   // result fields that do not depend on the store depth
   typedef struct packed {
      status_type          status;
      logic [DATA_W-1:0]   read_data;
      logic                read_valid;
      logic                overflow;
      logic [COUNT_W-1:0]  release_count;
      logic [COUNT_W-1:0]  words_written;
   } rsp_type;

endpackage
`default_nettype wire

// ----- hdl/log_entry_ring_buffer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// log_entry_ring_buffer
// Word-wide circular trace buffer for log entries with peek and release.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Entry starts,
// parameter words, releases, clear-all and unused codes are captured and
// then executed; a peek that passes its check also waits on the word
// store read. A release whose amount is at or above DEPTH_WORDS first
// passes through a reduce step that takes DEPTH_WORDS off the amount
// until it is below the depth. The result of an item is marked by
// rsp_strobe, high for exactly one cycle, in the cycle after its last
// step; nothing holds it, so it must be taken then. After reset and after
// every clear-all the store is zeroed one word a cycle, over all
// DEPTH_WORDS words, with busy high. The sequencer takes one item at a
// time. The flush threshold can be written at any time through csr_; it is always ready.
module log_entry_ring_buffer #(
   parameter int DEPTH_WORDS = 1024,
   parameter int MAX_PARAMS  = 63
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // configuration
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [lerb_pkg::THRESH_W-1:0]    csr_wdata,
   // items
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [lerb_pkg::OP_W-1:0]        req_op,
   input  wire logic [lerb_pkg::DATA_W-1:0]      req_data_word,
   input  wire logic [lerb_pkg::PCOUNT_W-1:0]    req_param_count,
   input  wire logic [lerb_pkg::AMOUNT_W-1:0]    req_amount,
   // results
   output logic                                  rsp_strobe,
   output logic      [1:0]                       rsp_status,
   output logic      [lerb_pkg::DATA_W-1:0]      rsp_read_data,
   output logic                                  rsp_read_valid,
   output logic      [lerb_pkg::USAGE_W-1:0]     rsp_usage,
   output logic                                  rsp_flush_needed,
   output logic                                  rsp_overflow,
   output logic      [lerb_pkg::COUNT_W-1:0]     rsp_release_count,
   output logic      [lerb_pkg::COUNT_W-1:0]     rsp_words_written
);

   localparam int PTR_W = $clog2(DEPTH_WORDS);
   localparam int CMP_W = (PTR_W > lerb_pkg::THRESH_W) ? PTR_W : lerb_pkg::THRESH_W;
   localparam int UEX_W = (PTR_W > lerb_pkg::USAGE_W) ? PTR_W : lerb_pkg::USAGE_W;

   logic                              mem_we;
   logic [PTR_W-1:0]                  mem_waddr;
   logic [lerb_pkg::DATA_W-1:0]       mem_wdata;
   logic [PTR_W-1:0]                  mem_raddr;
   logic [lerb_pkg::DATA_W-1:0]       mem_rdata;
   logic                              res_valid;
   lerb_pkg::rsp_type                 res;
   logic [PTR_W-1:0]                  res_usage;
   logic [UEX_W-1:0]                  usage_ext;

   logic [lerb_pkg::THRESH_W-1:0]     thresh_ff;
   logic                              strobe_ff;
   lerb_pkg::rsp_type                 rsp_ff;
   logic [lerb_pkg::USAGE_W-1:0]      usage_ff;
   logic                              flush_ff;

   lerb_word_mem #(
      .DEPTH_WORDS (DEPTH_WORDS),
      .ADDR_W      (PTR_W),
      .DATA_W      (lerb_pkg::DATA_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   lerb_seq #(
      .DEPTH_WORDS (DEPTH_WORDS),
      .MAX_PARAMS  (MAX_PARAMS),
      .PTR_W       (PTR_W)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_data_word   (req_data_word),
      .req_param_count (req_param_count),
      .req_amount      (req_amount),
      .mem_we          (mem_we),
      .mem_waddr       (mem_waddr),
      .mem_wdata       (mem_wdata),
      .mem_raddr       (mem_raddr),
      .mem_rdata       (mem_rdata),
      .res_valid       (res_valid),
      .res             (res),
      .res_usage       (res_usage)
   );

   // flush threshold register, every transfer taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= lerb_pkg::THRESH_RESET;
      end else if (csr_valid && csr_ready) begin
         thresh_ff <= csr_wdata;
      end
   end

   assign usage_ext = UEX_W'(res_usage);

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= res_valid;
      end
   end

   // result payload and flush compare
   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff   <= res;
         usage_ff <= usage_ext[lerb_pkg::USAGE_W-1:0];
         flush_ff <= (CMP_W'(res_usage) >= CMP_W'(thresh_ff));
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_read_data     = rsp_ff.read_data;
   assign rsp_read_valid    = rsp_ff.read_valid;
   assign rsp_usage         = usage_ff;
   assign rsp_flush_needed  = flush_ff;
   assign rsp_overflow      = rsp_ff.overflow;
   assign rsp_release_count = rsp_ff.release_count;
   assign rsp_words_written = rsp_ff.words_written;

endmodule
`default_nettype wire

// ----- hdl/lerb_word_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lerb_word_mem
// Word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lerb_word_mem #(
   parameter int DEPTH_WORDS = 1024,
   parameter int ADDR_W      = 10,
   parameter int DATA_W      = 32
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [DATA_W-1:0] wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH_WORDS];
   logic [DATA_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- hdl/lerb_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lerb_seq
// Item sequencer: holds the ring pointers and counters, drives the word
// store, runs the clearing pass and builds one result per item.
// ----------------------------------------------------------------------------
module lerb_seq #(
   parameter int DEPTH_WORDS = 1024,
   parameter int MAX_PARAMS  = 63,
   parameter int PTR_W       = 10
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input items
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [lerb_pkg::OP_W-1:0]       req_op,
   input  wire logic [lerb_pkg::DATA_W-1:0]     req_data_word,
   input  wire logic [lerb_pkg::PCOUNT_W-1:0]   req_param_count,
   input  wire logic [lerb_pkg::AMOUNT_W-1:0]   req_amount,
   // word store
   output logic                                 mem_we,
   output logic      [PTR_W-1:0]                mem_waddr,
   output logic      [lerb_pkg::DATA_W-1:0]     mem_wdata,
   output logic      [PTR_W-1:0]                mem_raddr,
   input  wire logic [lerb_pkg::DATA_W-1:0]     mem_rdata,
   // result
   output logic                                 res_valid,
   output lerb_pkg::rsp_type                    res,
   output logic      [PTR_W-1:0]                res_usage
);

   localparam int SUM_W = ((PTR_W > lerb_pkg::AMOUNT_W) ? PTR_W : lerb_pkg::AMOUNT_W) + 1;
   localparam int LEN_W = ((PTR_W > lerb_pkg::PCOUNT_W) ? PTR_W : lerb_pkg::PCOUNT_W) + 2;
   localparam logic [PTR_W-1:0] LAST_ADDR = PTR_W'(DEPTH_WORDS - 1);
   localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(DEPTH_WORDS);
   localparam logic [LEN_W-1:0] DEPTH_L   = LEN_W'(DEPTH_WORDS);
   localparam logic [lerb_pkg::PCOUNT_W-1:0] MAX_P = lerb_pkg::PCOUNT_W'(MAX_PARAMS);

   lerb_pkg::state_type                 state_ff, state_in;
   logic [lerb_pkg::OP_W-1:0]           op_ff, op_in;
   logic [lerb_pkg::DATA_W-1:0]         data_ff, data_in;
   logic [lerb_pkg::PCOUNT_W-1:0]       pcount_ff, pcount_in;
   logic [lerb_pkg::AMOUNT_W-1:0]       amount_ff, amount_in;
   logic [PTR_W-1:0]                    wp_ff, wp_in;
   logic [PTR_W-1:0]                    rp_ff, rp_in;
   logic                                ovf_ff, ovf_in;
   logic [lerb_pkg::PCOUNT_W-1:0]       pend_ff, pend_in;
   logic [lerb_pkg::COUNT_W-1:0]        rel_ff, rel_in;
   logic [lerb_pkg::COUNT_W-1:0]        wr_ff, wr_in;
   logic [PTR_W-1:0]                    clr_ff, clr_in;

   logic                                accept;
   logic [PTR_W-1:0]                    usage_cur;
   logic [SUM_W-1:0]                    ptr_sum;
   logic [PTR_W-1:0]                    ptr_mod;
   logic [SUM_W-1:0]                    amt_red;
   logic                                req_amt_big;
   logic                                peek_fail;
   logic [LEN_W-1:0]                    required;
   logic [LEN_W-1:0]                    free_words;
   logic                                too_large;
   logic                                no_room;
   logic [PTR_W-1:0]                    entry_base;

   // words held between the two pointers
   function automatic logic [PTR_W-1:0] usage_of(input logic [PTR_W-1:0] wp,
                                                 input logic [PTR_W-1:0] rp);
      logic [PTR_W:0] diff;
      if (wp >= rp) begin
         diff = {1'b0, wp} - {1'b0, rp};
      end else begin
         diff = (PTR_W+1)'(DEPTH_WORDS) - {1'b0, rp} + {1'b0, wp};
      end
      return diff[PTR_W-1:0];
   endfunction

   // pointer step with wrap at the depth
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == LAST_ADDR) ? '0 : p + PTR_W'(1);
   endfunction

   assign busy   = (state_ff != lerb_pkg::S_IDLE);
   assign accept = start && !busy;

   // shared arithmetic on the latched item
   always_comb begin
      usage_cur   = usage_of(wp_ff, rp_ff);
      ptr_sum     = SUM_W'(rp_ff) + SUM_W'(amount_ff);
      ptr_mod     = (ptr_sum >= DEPTH_S) ? PTR_W'(ptr_sum - DEPTH_S) : PTR_W'(ptr_sum);
      amt_red     = SUM_W'(amount_ff) - DEPTH_S;
      req_amt_big = (SUM_W'(req_amount) >= DEPTH_S);
      peek_fail   = (SUM_W'(amount_ff) >= SUM_W'(usage_cur));
      required    = LEN_W'(pcount_ff) + LEN_W'(1);
      free_words  = DEPTH_L - LEN_W'(usage_cur);
      too_large   = (pcount_ff > MAX_P) || (required > DEPTH_L);
      no_room     = (required > free_words);
      entry_base  = no_room ? '0 : wp_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lerb_pkg::S_CLEAR: begin
            if (clr_ff == LAST_ADDR) begin
               state_in = lerb_pkg::S_IDLE;
            end
         end
         lerb_pkg::S_IDLE: begin
            if (accept) begin
               if ((lerb_pkg::op_type'(req_op) == lerb_pkg::OP_RELEASE) && req_amt_big) begin
                  state_in = lerb_pkg::S_REDUCE;
               end else begin
                  state_in = lerb_pkg::S_EXEC;
               end
            end
         end
         lerb_pkg::S_REDUCE: begin
            if (amt_red < DEPTH_S) begin
               state_in = lerb_pkg::S_EXEC;
            end
         end
         lerb_pkg::S_EXEC: begin
            case (lerb_pkg::op_type'(op_ff))
               lerb_pkg::OP_PEEK: begin
                  state_in = peek_fail ? lerb_pkg::S_IDLE : lerb_pkg::S_PEEK;
               end
               lerb_pkg::OP_CLEAR_ALL: begin
                  state_in = lerb_pkg::S_CLEAR;
               end
               default: begin
                  state_in = lerb_pkg::S_IDLE;
               end
            endcase
         end
         lerb_pkg::S_PEEK: begin
            state_in = lerb_pkg::S_IDLE;
         end
         default: begin
            state_in = lerb_pkg::S_IDLE;
         end
      endcase
   end

   // datapath, store access and result
   always_comb begin
      op_in      = op_ff;
      data_in    = data_ff;
      pcount_in  = pcount_ff;
      amount_in  = amount_ff;
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      ovf_in     = ovf_ff;
      pend_in    = pend_ff;
      rel_in     = rel_ff;
      wr_in      = wr_ff;
      clr_in     = clr_ff;
      mem_we     = 1'b0;
      mem_waddr  = wp_ff;
      mem_wdata  = data_ff;
      mem_raddr  = ptr_mod;
      res_valid  = 1'b0;
      res.status     = lerb_pkg::ST_OK;
      res.read_data  = '0;
      res.read_valid = 1'b0;
      case (state_ff)
         // zero sweep over the store
         lerb_pkg::S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = ptr_inc(clr_ff);
         end
         // capture the item
         lerb_pkg::S_IDLE: begin
            if (accept) begin
               op_in     = req_op;
               data_in   = req_data_word;
               pcount_in = req_param_count;
               amount_in = req_amount;
            end
         end
         // bring a release amount below the depth
         lerb_pkg::S_REDUCE: begin
            amount_in = lerb_pkg::AMOUNT_W'(amt_red);
         end
         lerb_pkg::S_EXEC: begin
            res_valid = 1'b1;
            case (lerb_pkg::op_type'(op_ff))
               lerb_pkg::OP_ENTRY_START: begin
                  if (too_large) begin
                     res.status = lerb_pkg::ST_TOO_LARGE;
                     pend_in    = '0;
                  end else begin
                     // restart at the bottom when the entry does not fit
                     if (no_room) begin
                        ovf_in = 1'b1;
                     end
                     mem_we    = 1'b1;
                     mem_waddr = entry_base;
                     wp_in     = ptr_inc(entry_base);
                     wr_in     = wr_ff + lerb_pkg::COUNT_W'(1);
                     pend_in   = pcount_ff;
                  end
               end
               lerb_pkg::OP_PARAM_WORD: begin
                  if (pend_ff == '0) begin
                     res.status = lerb_pkg::ST_NO_PARAM;
                  end else begin
                     mem_we  = 1'b1;
                     wp_in   = ptr_inc(wp_ff);
                     wr_in   = wr_ff + lerb_pkg::COUNT_W'(1);
                     pend_in = pend_ff - lerb_pkg::PCOUNT_W'(1);
                  end
               end
               lerb_pkg::OP_PEEK: begin
                  // read issued now, result follows with the store data
                  if (peek_fail) begin
                     res.status = lerb_pkg::ST_PEEK_FAIL;
                  end else begin
                     res_valid = 1'b0;
                  end
               end
               lerb_pkg::OP_RELEASE: begin
                  if (ptr_mod == wp_ff) begin
                     rp_in  = '0;
                     wp_in  = '0;
                     ovf_in = 1'b0;
                  end else begin
                     rp_in = ptr_mod;
                  end
                  rel_in = rel_ff + lerb_pkg::COUNT_W'(1);
               end
               lerb_pkg::OP_CLEAR_ALL: begin
                  wp_in   = '0;
                  rp_in   = '0;
                  ovf_in  = 1'b0;
                  pend_in = '0;
                  clr_in  = '0;
               end
               default: begin
                  res.status = lerb_pkg::ST_OK;
               end
            endcase
         end
         // peeked word returns from the store
         lerb_pkg::S_PEEK: begin
            res_valid      = 1'b1;
            res.read_valid = 1'b1;
            res.read_data  = mem_rdata;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
      res.overflow      = ovf_in;
      res.release_count = rel_in;
      res.words_written = wr_in;
      res_usage         = usage_of(wp_in, rp_in);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lerb_pkg::S_CLEAR;
         wp_ff    <= '0;
         rp_ff    <= '0;
         ovf_ff   <= 1'b0;
         pend_ff  <= '0;
         rel_ff   <= '0;
         wr_ff    <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         ovf_ff   <= ovf_in;
         pend_ff  <= pend_in;
         rel_ff   <= rel_in;
         wr_ff    <= wr_in;
         clr_ff   <= clr_in;
      end
   end

   // item payload
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      data_ff   <= data_in;
      pcount_ff <= pcount_in;
      amount_ff <= amount_in;
   end

endmodule
`default_nettype wire

// ----- hdl/lerb_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lerb_checker
// Port-level checks of the log entry ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module lerb_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             start,
   input wire logic                             busy,
   input wire logic                             rsp_strobe,
   input wire logic [1:0]                       rsp_status,
   input wire logic [lerb_pkg::DATA_W-1:0]      rsp_read_data,
   input wire logic                             rsp_read_valid
);

   // reset starts the clearing pass
   a_reset_clears: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low after reset");

   // an accepted item keeps the block busy while it executes
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after item transfer");

   // one item at a time, so results never come back to back
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results on consecutive cycles");

   // a valid peek always reports success
   a_peek_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_read_valid) |-> (rsp_status == lerb_pkg::ST_OK))
      else $error("peek data with failing status");

   // read data is zero unless a peek delivered it
   a_rdata_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_read_valid) |-> (rsp_read_data == '0))
      else $error("read data set without a peek");

endmodule

bind log_entry_ring_buffer lerb_checker u_lerb_checker (.*);
`default_nettype wire
